@@ rtl/core/twde_pkg.sv @@
// Package for the tile word dictionary encoder.
// Holds the payload structs and fixed field widths; no dependencies.
package twde_pkg;
  localparam int TileW = 12;
  localparam int IdW   = 10;
  localparam int OutTiles = 4;

  typedef struct packed {
    logic [TileW-1:0] tile_index;
    logic             row_end;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]   word_id;
    logic             is_new;
    logic [TileW-1:0] tile_a;
    logic [TileW-1:0] tile_b;
    logic [TileW-1:0] tile_c;
    logic [TileW-1:0] tile_d;
    logic             dict_full;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } scan_state_t;
endpackage

@@ rtl/core/twde_gather.sv @@
// Front part: gathers tiles into padded words and queues them.
// Depends on twde_pkg.
module twde_gather #(
  parameter int WORD_TILES = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  twde_pkg::in_item_t                     in_item,
  output logic                                   word_valid,
  input  logic                                   word_take,
  output logic [WORD_TILES*twde_pkg::TileW-1:0]  word
);
  localparam int CntW = (WORD_TILES > 1) ? $clog2(WORD_TILES) : 1;
  localparam int WW = WORD_TILES*twde_pkg::TileW;

  logic [WW-1:0] gather;
  logic [CntW-1:0] count;
  logic [WW-1:0] q [2];
  logic [1:0] qcnt;
  logic rd_ptr, wr_ptr;
  logic [WW-1:0] word_next;
  logic accept, done;

  assign full = (qcnt == 2'd2);
  assign accept = push && !full;
  assign done = in_item.row_end || ({1'b0, count} == (CntW+1)'(WORD_TILES-1));

  always_comb begin
    word_next = gather;
    word_next[count*twde_pkg::TileW +: twde_pkg::TileW] = in_item.tile_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gather <= '0;
      count <= '0;
      qcnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (accept) begin
        if (done) begin
          q[wr_ptr] <= word_next;
          wr_ptr <= !wr_ptr;
          gather <= '0;
          count <= '0;
        end else begin
          gather <= word_next;
          count <= count + 1'b1;
        end
      end
      if (word_take) rd_ptr <= !rd_ptr;
      qcnt <= qcnt + {1'b0, accept && done} - {1'b0, word_take};
    end
  end

  assign word_valid = (qcnt != 2'd0);
  assign word = q[rd_ptr];
endmodule

@@ rtl/core/twde_lookup.sv @@
// Back part: scans the dictionary memory one entry a cycle, appends unseen words while it has room.
// Depends on twde_pkg.
module twde_lookup #(
  parameter int DICT_DEPTH = 1024,
  parameter int WORD_TILES = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  word_valid,
  output logic                                  word_take,
  input  logic [WORD_TILES*twde_pkg::TileW-1:0] word,
  output logic                                  res_valid,
  input  logic                                  res_take,
  output twde_pkg::out_item_t                   res
);
  localparam int WW = WORD_TILES*twde_pkg::TileW;
  localparam int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int CW = $clog2(DICT_DEPTH+1);

  twde_pkg::scan_state_t state, state_next;
  logic [WW-1:0] mem [DICT_DEPTH];
  logic [WW-1:0] rd_data;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] idx;
  logic [CW-1:0] rd_idx;
  logic rd_ok;
  logic [WW-1:0] cur;
  logic hit, scan_end, is_full;
  logic [WW+twde_pkg::TileW*twde_pkg::OutTiles-1:0] padded;

  assign hit = rd_ok && ((rd_idx == '0) ? (cur == '0) : (rd_data == cur));
  assign scan_end = rd_ok && (rd_idx + 1'b1 == entry_count);
  assign is_full = (entry_count == CW'(DICT_DEPTH));

  always_comb begin
    state_next = state;
    case (state)
      twde_pkg::ST_IDLE: if (word_valid && !res_valid) state_next = twde_pkg::ST_SCAN;
      twde_pkg::ST_SCAN: if (hit || scan_end) state_next = twde_pkg::ST_DONE;
      twde_pkg::ST_DONE: state_next = twde_pkg::ST_IDLE;
      default: state_next = twde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    word_take = (state == twde_pkg::ST_IDLE) && word_valid && !res_valid;
  end

  assign padded = {{(twde_pkg::TileW*twde_pkg::OutTiles){1'b0}}, cur};

  always_ff @(posedge clk) begin
    rd_data <= mem[idx[AW-1:0]];
    if (state == twde_pkg::ST_SCAN && !hit && scan_end && !is_full)
      mem[entry_count[AW-1:0]] <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twde_pkg::ST_IDLE;
      entry_count <= CW'(1);
      idx <= '0;
      rd_ok <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_take) res_valid <= 1'b0;
      case (state)
        twde_pkg::ST_IDLE: begin
          rd_ok <= 1'b0;
          if (word_take) begin
            cur <= word;
            idx <= '0;
          end
        end
        twde_pkg::ST_SCAN: begin
          rd_ok <= !(hit || scan_end);
          rd_idx <= idx;
          if (idx + 1'b1 < entry_count) idx <= idx + 1'b1;
          if (hit) begin
            res.word_id <= twde_pkg::IdW'(rd_idx);
            res.is_new <= 1'b0;
            res.dict_full <= 1'b0;
          end else if (scan_end) begin
            res.word_id <= is_full ? '0 : twde_pkg::IdW'(entry_count);
            res.is_new <= !is_full;
            res.dict_full <= is_full;
            if (!is_full) entry_count <= entry_count + 1'b1;
          end
          res.tile_a <= padded[0 +: twde_pkg::TileW];
          res.tile_b <= padded[twde_pkg::TileW +: twde_pkg::TileW];
          res.tile_c <= padded[2*twde_pkg::TileW +: twde_pkg::TileW];
          res.tile_d <= padded[3*twde_pkg::TileW +: twde_pkg::TileW];
        end
        twde_pkg::ST_DONE: res_valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/core/tile_word_dictionary_encoder_top.sv @@
// Top level of the tile word dictionary encoder.
// Depends on twde_pkg, twde_gather, twde_lookup.
//
// channel  | handshake   | payload
// input    | push/full   | in_item  (tile_index, row_end)
// result   | pop/empty   | out_item (word_id, is_new, tiles, dict_full)
//
// A tile is taken each cycle while the two-word queue has room.
// A taken word is scanned with one memory read per stored entry, fewer on an early match,
// then passes the done state, which registers the result valid.
// The next word is taken only after a pop has cleared that result valid and a word is queued.
// Reset is synchronous; the dictionary holds only entry 0 afterward.
// Either side may stall freely; the queue decouples gathering from lookup.
module tile_word_dictionary_encoder_top #(
  parameter int DICT_DEPTH = 1024,
  parameter int WORD_TILES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  twde_pkg::in_item_t   in_item,
  output logic                 empty,
  input  logic                 pop,
  output twde_pkg::out_item_t  out_item
);
  logic wv, wt, rv;
  logic [WORD_TILES*twde_pkg::TileW-1:0] w;

  twde_gather #(.WORD_TILES(WORD_TILES)) u_gather (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .word_valid(wv), .word_take(wt), .word(w)
  );

  twde_lookup #(.DICT_DEPTH(DICT_DEPTH), .WORD_TILES(WORD_TILES)) u_lookup (
    .clk(clk), .rst(rst), .word_valid(wv), .word_take(wt), .word(w),
    .res_valid(rv), .res_take(pop && rv), .res(out_item)
  );

  assign empty = !rv;
endmodule

@@ rtl/core/twde_checker.sv @@
// Port checker for the tile word dictionary encoder, bound to the top level.
// Depends on twde_pkg.
module twde_checker (
  input logic                clk,
  input logic                rst,
  input logic                empty,
  input logic                pop,
  input twde_pkg::out_item_t out_item
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item)) else $error("result dropped");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(out_item.is_new && out_item.dict_full)) else $error("flag clash");
  a_fullid: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.dict_full |-> out_item.word_id == '0) else $error("full id");
  a_newid: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.is_new |-> out_item.word_id != '0) else $error("new id zero");
endmodule

bind tile_word_dictionary_encoder_top twde_checker u_chk (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .out_item(out_item)
);

@@ dv/tile_word_dictionary_encoder_top_tb.sv @@
// Testbench for tile_word_dictionary_encoder_top: random and directed tile streams,
// a word dictionary predictor in a scoreboard class, random stalls on both sides.
// Depends on twde_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tile_word_dictionary_encoder_top_tb;

  localparam int DictDepth = 1024;
  localparam int WordTiles = 4;
  localparam int QuietLimit = 6000;

  class word_dict_scoreboard;
    logic [twde_pkg::TileW-1:0] gather[WordTiles];
    int gathered;
    logic [48-1:0] entries[DictDepth];
    int entry_count;
    twde_pkg::out_item_t pending_words[$];
    int mismatches;
    int words_seen;
    int full_hits;
    int new_words;

    function new();
      gathered = 0;
      entry_count = 1;
      entries[0] = '0;
      mismatches = 0;
      words_seen = 0;
      full_hits = 0;
      new_words = 0;
      foreach (gather[i]) gather[i] = '0;
    endfunction

    function void note_tile(twde_pkg::in_item_t it);
      logic [48-1:0] w;
      twde_pkg::out_item_t r;
      int hit;
      gather[gathered] = it.tile_index;
      gathered++;
      if (gathered < WordTiles && !it.row_end) return;
      w = '0;
      for (int i = 0; i < WordTiles; i++)
        if (i < gathered) w[48-1-i*twde_pkg::TileW -: twde_pkg::TileW] = gather[i];
      gathered = 0;
      foreach (gather[i]) gather[i] = '0;
      hit = -1;
      for (int i = 0; i < entry_count; i++)
        if (hit < 0 && entries[i] == w) hit = i;
      r = '0;
      {r.tile_a, r.tile_b, r.tile_c, r.tile_d} = w;
      if (hit >= 0) begin
        r.word_id = hit[twde_pkg::IdW-1:0];
      end else if (entry_count < DictDepth) begin
        entries[entry_count] = w;
        r.word_id = entry_count[twde_pkg::IdW-1:0];
        r.is_new = 1'b1;
        entry_count++;
        new_words++;
      end else begin
        r.dict_full = 1'b1;
        full_hits++;
      end
      pending_words.push_back(r);
    endfunction

    function void check_word(twde_pkg::out_item_t got);
      twde_pkg::out_item_t exp_w;
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.word_id !== exp_w.word_id || got.is_new !== exp_w.is_new ||
          got.tile_a !== exp_w.tile_a || got.tile_b !== exp_w.tile_b ||
          got.tile_c !== exp_w.tile_c || got.tile_d !== exp_w.tile_d ||
          got.dict_full !== exp_w.dict_full) begin
        mismatches++;
        if (mismatches <= 10) $display("word mismatch: expected %p actual %p", exp_w, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  twde_pkg::in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  twde_pkg::out_item_t out_item;

  word_dict_scoreboard sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  logic [48-1:0] history[$];

  tile_word_dictionary_encoder_top #(.DICT_DEPTH(DictDepth), .WORD_TILES(WordTiles)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_word(out_item);
      if ((pop && !empty) || (push && !full)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= QuietLimit) begin
        $display("FAIL tile_word_dictionary_encoder_top");
        $finish;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall_left <= $urandom_range(0, 5);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_tile(logic [twde_pkg::TileW-1:0] tile, logic last);
    twde_pkg::in_item_t it;
    it.tile_index = tile;
    it.row_end = last;
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note_tile(it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_word(logic [48-1:0] w, int len, logic last);
    for (int i = 0; i < len; i++)
      send_tile(w[48-1-i*twde_pkg::TileW -: twde_pkg::TileW],
                (i == len - 1) ? last : 1'b0);
  endtask

  task automatic drain_words();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [48-1:0] w;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(48'h0, 4, 1'b0);
    send_word(48'hFFF_FFF_FFF_FFF, 4, 1'b0);
    send_word(48'hFFF_FFF_FFF_FFF, 4, 1'b1);
    send_tile(12'hABC, 1'b1);
    send_tile(12'h000, 1'b1);
    send_word(48'h001_002_000_000, 2, 1'b1);
    send_word(48'h001_002_003_000, 3, 1'b1);
    send_word(48'h001_002_000_000, 2, 1'b1);
    send_word(48'h800_400_200_100, 4, 1'b0);
    send_word(48'h555_AAA_555_AAA, 4, 1'b1);
    drain_words();

    for (int n = 0; n < 170; n++) begin
      len = $urandom_range(1, 4);
      if (history.size() != 0 && $urandom_range(0, 2) == 0)
        w = history[$urandom_range(0, history.size() - 1)];
      else
        w = 48'({$urandom(), $urandom()});
      if ($urandom_range(0, 9) == 0) begin
        send_tile(twde_pkg::TileW'($urandom()), 1'($urandom_range(0, 1)));
      end else begin
        for (int i = len; i < 4; i++) w[48-1-i*twde_pkg::TileW -: twde_pkg::TileW] = '0;
        history.push_back(w);
        send_word(w, len, (len < 4) ? 1'b1 : 1'(($urandom_range(0, 1))));
      end
    end
    send_tile(twde_pkg::TileW'($urandom()), 1'b1);

    while (sb.entry_count < DictDepth) send_tile(twde_pkg::TileW'($urandom()), 1'b1);
    quiet = 1'b1;
    for (int n = 0; n < 12; n++) begin
      send_tile(twde_pkg::TileW'($urandom()), 1'b1);
      send_word(history[$urandom_range(0, history.size() - 1)], 4, 1'b0);
    end

    drain_words();
    repeat (1100) @(posedge clk);
    $display("covered %0d words, %0d new entries, %0d refused with dictionary full",
             sb.words_seen, sb.new_words, sb.full_hits);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0)
      $display("PASS tile_word_dictionary_encoder_top");
    else
      $display("FAIL tile_word_dictionary_encoder_top");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/twde_pkg.sv
rtl/core/twde_gather.sv
rtl/core/twde_lookup.sv
rtl/core/tile_word_dictionary_encoder_top.sv
rtl/core/twde_checker.sv
dv/tile_word_dictionary_encoder_top_tb.sv
